### rtl/cpa_pkg.sv
`timescale 1ns / 1ps

package cpa_pkg;

  // field widths
  localparam int ModeW  = 2;
  localparam int PixelW = 32;
  localparam int ChanW  = 8;

  // operating modes
  localparam logic [ModeW-1:0] MODE_SCAN = 2'd0;
  localparam logic [ModeW-1:0] MODE_EMIT = 2'd1;
  localparam logic [ModeW-1:0] MODE_MONO = 2'd2;

  // fixed pixel values
  localparam logic [PixelW-1:0] OPAQUE_BLACK = 32'hff00_0000;
  localparam logic [PixelW-1:0] OPAQUE_WHITE = 32'hffff_ffff;
  localparam logic [PixelW-1:0] TRANSPARENT  = 32'h0000_0000;
  localparam logic [ChanW-1:0]  FULL_ALPHA   = 8'd255;

  // floor(c * a / 255) with the divide done as add and shift, exact for c, a <= 255
  function automatic logic [ChanW-1:0] scale_chan(input logic [ChanW-1:0] c,
                                                  input logic [ChanW-1:0] a);
    logic [2*ChanW-1:0] prod;
    logic [2*ChanW:0]   sum;
    prod = {8'd0, c} * {8'd0, a};
    sum  = {1'b0, prod} + {9'd0, prod[2*ChanW-1:ChanW]} + 17'd1;
    return sum[2*ChanW-1:ChanW];
  endfunction

endpackage

### rtl/cpa_if.sv
`timescale 1ns / 1ps

// input pixel channel
interface cpa_in_if;
  logic                          valid;
  logic                          ready;
  logic [cpa_pkg::ModeW-1:0]     mode;
  logic [cpa_pkg::PixelW-1:0]    pixel_argb;
  logic                          and_bit;
  logic                          xor_bit;
  logic                          first_pixel;

  modport source (output valid, mode, pixel_argb, and_bit, xor_bit, first_pixel,
                  input ready);
  modport sink (input valid, mode, pixel_argb, and_bit, xor_bit, first_pixel,
                output ready);
endinterface

// converted pixel channel
interface cpa_out_if;
  logic                          valid;
  logic                          ready;
  logic [cpa_pkg::PixelW-1:0]    out_argb;
  logic                          alpha_present;

  modport source (output valid, out_argb, alpha_present, input ready);
  modport sink (input valid, out_argb, alpha_present, output ready);
endinterface

### rtl/cursor_image_to_premultiplied_argb.sv
`timescale 1ns / 1ps

// an accepted transaction passes the input register and then the result register before its result is offered
// throughput: one pixel per cycle while the output is not stalled, set by the single stage of three 8x8 multiplies
// scan pixels and unused mode codes produce no output transaction
// reset (rst, synchronous, active high) empties both stages and clears the alpha flag
module cursor_image_to_premultiplied_argb (
  input  logic clk,
  input  logic rst,
  cpa_in_if.sink    pix_in,
  cpa_out_if.source pix_out
);

  // input stage
  logic                           a_valid;
  logic [cpa_pkg::ModeW-1:0]      a_mode;
  logic [cpa_pkg::PixelW-1:0]     a_pixel;
  logic                           a_and;
  logic                           a_xor;
  logic                           a_first;

  // result stage
  logic                           r_valid;
  logic [cpa_pkg::PixelW-1:0]     r_argb;
  logic                           r_alpha;

  logic                           alpha_seen;
  logic                           alpha_seen_next;
  logic                           s_adv;
  logic                           a_emits;
  logic [cpa_pkg::ChanW-1:0]      alpha_eff;
  logic [cpa_pkg::PixelW-1:0]     argb_next;
  logic                           alpha_nonzero;

  assign s_adv   = a_valid && (!r_valid || pix_out.ready);
  assign a_emits = (a_mode == cpa_pkg::MODE_EMIT) || (a_mode == cpa_pkg::MODE_MONO);
  assign pix_in.ready = !a_valid || s_adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (pix_in.ready) begin
      a_valid <= pix_in.valid;
    end
    if (pix_in.ready && pix_in.valid) begin
      a_mode  <= pix_in.mode;
      a_pixel <= pix_in.pixel_argb;
      a_and   <= pix_in.and_bit;
      a_xor   <= pix_in.xor_bit;
      a_first <= pix_in.first_pixel;
    end
  end

  // scan flag update
  assign alpha_nonzero = (a_pixel[31:24] != '0);

  always_comb begin
    alpha_seen_next = alpha_seen;
    if (s_adv && a_mode == cpa_pkg::MODE_SCAN) begin
      alpha_seen_next = a_first ? alpha_nonzero : (alpha_seen || alpha_nonzero);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_seen <= 1'b0;
    end else begin
      alpha_seen <= alpha_seen_next;
    end
  end

  // pixel conversion; alpha zero yields all-zero products on its own
  assign alpha_eff = (!alpha_seen && !a_and) ? cpa_pkg::FULL_ALPHA : a_pixel[31:24];

  always_comb begin
    if (a_mode == cpa_pkg::MODE_MONO) begin
      if (a_and && !a_xor) begin
        argb_next = cpa_pkg::TRANSPARENT;
      end else if (a_xor && !a_and) begin
        argb_next = cpa_pkg::OPAQUE_WHITE;
      end else begin
        argb_next = cpa_pkg::OPAQUE_BLACK;
      end
    end else begin
      argb_next = {alpha_eff,
                   cpa_pkg::scale_chan(a_pixel[23:16], alpha_eff),
                   cpa_pkg::scale_chan(a_pixel[15:8], alpha_eff),
                   cpa_pkg::scale_chan(a_pixel[7:0], alpha_eff)};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (s_adv) begin
      r_valid <= a_emits;
    end else if (pix_out.ready) begin
      r_valid <= 1'b0;
    end
    if (s_adv && a_emits) begin
      r_argb  <= argb_next;
      r_alpha <= (a_mode == cpa_pkg::MODE_EMIT) ? alpha_seen : 1'b0;
    end
  end

  assign pix_out.valid         = r_valid;
  assign pix_out.out_argb      = r_argb;
  assign pix_out.alpha_present = r_alpha;

`ifndef SYNTH
  // a new result only comes from an emitting pixel leaving the input stage
  a_rose_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(r_valid) |-> $past(s_adv && a_emits))
    else $error("result appeared without an emitting pixel");

  // the alpha flag moves only on a scan pixel
  a_flag_from_scan: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && alpha_seen != $past(alpha_seen)) |->
      $past(s_adv && a_mode == cpa_pkg::MODE_SCAN))
    else $error("alpha flag changed outside a scan pixel");

  // an empty input stage always takes a transaction
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !a_valid |-> pix_in.ready)
    else $error("input stalled while empty");

  // zero alpha output must be fully transparent
  a_zero_alpha: assert property (@(posedge clk) disable iff (rst)
    (r_valid && r_argb[31:24] == 8'h00) |-> (r_argb == cpa_pkg::TRANSPARENT))
    else $error("zero alpha with nonzero color");
`endif

endmodule
